### hdl/awmd_pkg.sv
// Package with the transfer types and shared constants of the alpha-weighted mip downsampler.
`timescale 1ns / 1ps

package awmd_pkg;

    localparam int NUM_STAGES = 8;
    localparam int DIV_STAGES = 4;
    localparam int NUM_PIX = 4;
    localparam int NUM_CHAN = 3;
    localparam int CHAN_W = 8;
    localparam int PROD_W = 16;
    localparam int ASUM_W = 10;
    localparam int NUM_W = 18;
    localparam logic [PROD_W-1:0] ROUND_255 = 16'd127;

    typedef struct packed {
        logic [31:0] pixel_top_left;
        logic [31:0] pixel_top_right;
        logic [31:0] pixel_bottom_left;
        logic [31:0] pixel_bottom_right;
    } quad_t;

    typedef struct packed {
        logic [7:0] red_straight;
        logic [7:0] green_straight;
        logic [7:0] blue_straight;
        logic [7:0] alpha_mean;
        logic [7:0] red_premultiplied;
        logic [7:0] green_premultiplied;
        logic [7:0] blue_premultiplied;
    } texel_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][NUM_PIX-1:0][PROD_W-1:0] prod;
        logic [ASUM_W-1:0]                            asum;
    } mul_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][NUM_W-1:0]  rem;
        logic [NUM_CHAN-1:0][CHAN_W-1:0] quo;
        logic [ASUM_W-1:0]               asum;
    } div_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][CHAN_W-1:0] straight;
        logic [NUM_CHAN-1:0][PROD_W-1:0] prod;
        logic [CHAN_W-1:0]               amean;
    } pm_t;

endpackage

### hdl/alpha_weighted_mip_downsample_top.sv
// Top level of the alpha-weighted 2x2 mip downsampler: an eight-stage pipeline.
`timescale 1ns / 1ps

// Channel  Signals                            Direction  Content
// quad     quad_valid, quad_ready, quad      in         four straight RGBA8 texels
// texel    texel_valid, texel_ready, texel   out        straight color, alpha, premultiplied
//
// One quad is accepted per cycle while quad_ready is high; its texel leaves from the last stage.
// The stages are products, sums, four two-bit divider steps, the premultiply
// product and the divide by 255. Reset clears only the valid bits.
// A stage holds while the stage after it is full and stalled, so a stall
// fills bubbles first and loses or repeats no transfer.

module alpha_weighted_mip_downsample_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                quad_valid,
    output logic                quad_ready,
    input  awmd_pkg::quad_t     quad,
    output logic                texel_valid,
    input  logic                texel_ready,
    output awmd_pkg::texel_t    texel
);

    logic [awmd_pkg::NUM_STAGES-1:0] vld_reg;
    logic [awmd_pkg::NUM_STAGES-1:0] adv;

    awmd_pkg::mul_t   mul_reg;
    awmd_pkg::mul_t   mul_next;
    awmd_pkg::div_t   div_reg [awmd_pkg::DIV_STAGES+1];
    awmd_pkg::div_t   sum_next;
    awmd_pkg::div_t   div_next [awmd_pkg::DIV_STAGES];
    awmd_pkg::pm_t    pm_reg;
    awmd_pkg::pm_t    pm_next;
    awmd_pkg::texel_t out_reg;
    awmd_pkg::texel_t out_next;

    always_comb
    begin
        adv[awmd_pkg::NUM_STAGES-1] = ~vld_reg[awmd_pkg::NUM_STAGES-1] | texel_ready;
        for (int i = awmd_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = ~vld_reg[i] | adv[i+1];
        end
    end

    assign quad_ready  = adv[0];
    assign texel_valid = vld_reg[awmd_pkg::NUM_STAGES-1];
    assign texel       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= quad_valid;
            end
            for (int i = 1; i < awmd_pkg::NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 0: the twelve color-times-alpha products and the alpha sum.
    always_comb
    begin
        logic [awmd_pkg::NUM_PIX-1:0][31:0] px;
        logic [7:0] a;
        px[0] = quad.pixel_top_left;
        px[1] = quad.pixel_top_right;
        px[2] = quad.pixel_bottom_left;
        px[3] = quad.pixel_bottom_right;
        mul_next.asum = '0;
        for (int p = 0; p < awmd_pkg::NUM_PIX; p++)
        begin
            a = px[p][31:24];
            mul_next.asum = mul_next.asum + awmd_pkg::ASUM_W'(a);
            for (int c = 0; c < awmd_pkg::NUM_CHAN; c++)
            begin
                mul_next.prod[c][p] = awmd_pkg::PROD_W'(px[p][c*8 +: 8]) *
                                      awmd_pkg::PROD_W'(a);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mul_reg <= mul_next;
        end
    end

    // Stage 1: weighted sums plus half the alpha sum form the dividends.
    always_comb
    begin
        sum_next.asum = mul_reg.asum;
        sum_next.quo  = '0;
        for (int c = 0; c < awmd_pkg::NUM_CHAN; c++)
        begin
            sum_next.rem[c] = awmd_pkg::NUM_W'(mul_reg.asum[awmd_pkg::ASUM_W-1:1]);
            for (int p = 0; p < awmd_pkg::NUM_PIX; p++)
            begin
                sum_next.rem[c] = sum_next.rem[c] + awmd_pkg::NUM_W'(mul_reg.prod[c][p]);
            end
        end
    end

    // Stages 2 to 5: restoring division, two quotient bits per stage.
    always_comb
    begin
        logic [awmd_pkg::NUM_W-1:0] sh;
        for (int g = 0; g < awmd_pkg::DIV_STAGES; g++)
        begin
            div_next[g] = div_reg[g];
            for (int b = 0; b < 2; b++)
            begin
                sh = awmd_pkg::NUM_W'(div_reg[g].asum) << (7 - 2*g - b);
                for (int c = 0; c < awmd_pkg::NUM_CHAN; c++)
                begin
                    if (div_next[g].rem[c] >= sh)
                    begin
                        div_next[g].rem[c] = div_next[g].rem[c] - sh;
                        div_next[g].quo[c][7 - 2*g - b] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            div_reg[0] <= sum_next;
        end
        for (int g = 0; g < awmd_pkg::DIV_STAGES; g++)
        begin
            if (adv[g+2])
            begin
                div_reg[g+1] <= div_next[g];
            end
        end
    end

    // Stage 6: alpha mean and the premultiply products; a fully transparent quad gives zeros.
    always_comb
    begin
        logic [awmd_pkg::ASUM_W-1:0] asum_rnd;
        asum_rnd = div_reg[awmd_pkg::DIV_STAGES].asum + awmd_pkg::ASUM_W'(2);
        pm_next.amean = asum_rnd[awmd_pkg::ASUM_W-1:2];
        for (int c = 0; c < awmd_pkg::NUM_CHAN; c++)
        begin
            if (div_reg[awmd_pkg::DIV_STAGES].asum == '0)
            begin
                pm_next.straight[c] = '0;
            end
            else
            begin
                pm_next.straight[c] = div_reg[awmd_pkg::DIV_STAGES].quo[c];
            end
            pm_next.prod[c] = awmd_pkg::PROD_W'(pm_next.straight[c]) *
                              awmd_pkg::PROD_W'(pm_next.amean);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            pm_reg <= pm_next;
        end
    end

    // Stage 7: rounded divide by 255 as (x + 1 + (x >> 8)) >> 8.
    always_comb
    begin
        logic [awmd_pkg::NUM_CHAN-1:0][awmd_pkg::CHAN_W-1:0] pm;
        logic [awmd_pkg::PROD_W-1:0] x;
        logic [awmd_pkg::PROD_W-1:0] q;
        for (int c = 0; c < awmd_pkg::NUM_CHAN; c++)
        begin
            x = pm_reg.prod[c] + awmd_pkg::ROUND_255;
            q = x + awmd_pkg::PROD_W'(1) + awmd_pkg::PROD_W'(x[15:8]);
            pm[c] = q[15:8];
        end
        out_next.red_straight        = pm_reg.straight[0];
        out_next.green_straight      = pm_reg.straight[1];
        out_next.blue_straight       = pm_reg.straight[2];
        out_next.alpha_mean          = pm_reg.amean;
        out_next.red_premultiplied   = pm[0];
        out_next.green_premultiplied = pm[1];
        out_next.blue_premultiplied  = pm[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            out_reg <= out_next;
        end
    end

endmodule
